// File: rtl/core/hrm_pkg.sv
// hrm_pkg: shared constants, widths and helper functions for the hue rotation matrix unit
// no dependencies; used by hrm_cordic, hrm_combine and hue_rotation_matrix_unit
package hrm_pkg;

	localparam int ANGLE_BITS_DEF     = 16;
	localparam int COEF_FRAC_BITS_DEF = 14;

	localparam int CORDIC_STAGES = 20;
	localparam int CORDIC_W      = 34;
	localparam int PROD_W        = 68;
	localparam int COEF_W        = 16;
	localparam int PHASE_W       = 32;
	localparam int RESID_W       = 30;

	localparam int COMBINE_STAGES = 5;
	localparam int LATENCY        = CORDIC_STAGES + COMBINE_STAGES;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN   = CORDIC_W'(652032874);
	localparam logic signed [30:0]         Q30_THIRD     = 31'sd357913941;
	localparam logic signed [30:0]         Q30_INV_SQRT3 = 31'sd619925131;
	localparam int                         Q30_SHIFT     = 30;

	localparam logic signed [PROD_W-1:0] COEF_MAX = PROD_W'(32767);
	localparam logic signed [PROD_W-1:0] COEF_MIN = -PROD_W'(32768);

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic signed [CORDIC_W-1:0] atan_turn(input int idx);
		logic signed [CORDIC_W-1:0] v;
		begin
			case (idx)
				0:       v = CORDIC_W'(536870912);
				1:       v = CORDIC_W'(316933406);
				2:       v = CORDIC_W'(167458907);
				3:       v = CORDIC_W'(85004756);
				4:       v = CORDIC_W'(42667331);
				5:       v = CORDIC_W'(21354465);
				6:       v = CORDIC_W'(10679838);
				7:       v = CORDIC_W'(5340245);
				8:       v = CORDIC_W'(2670163);
				9:       v = CORDIC_W'(1335087);
				10:      v = CORDIC_W'(667544);
				11:      v = CORDIC_W'(333772);
				12:      v = CORDIC_W'(166886);
				13:      v = CORDIC_W'(83443);
				14:      v = CORDIC_W'(41722);
				15:      v = CORDIC_W'(20861);
				16:      v = CORDIC_W'(10430);
				17:      v = CORDIC_W'(5215);
				18:      v = CORDIC_W'(2608);
				19:      v = CORDIC_W'(1304);
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	// clamp a shifted coefficient to the signed output range
	function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [PROD_W-1:0] v);
		logic signed [COEF_W-1:0] r;
		begin
			if (v > COEF_MAX)
				r = COEF_MAX[COEF_W-1:0];
			else if (v < COEF_MIN)
				r = COEF_MIN[COEF_W-1:0];
			else
				r = v[COEF_W-1:0];
			return r;
		end
	endfunction

endpackage

// File: rtl/core/hrm_cordic.sv
// hrm_cordic: fully unrolled rotation-mode cordic, one iteration per register stage
// depends on hrm_pkg
module hrm_cordic #(
	parameter int ANGLE_BITS = hrm_pkg::ANGLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [ANGLE_BITS-1:0]                 angle,
	output logic                                  out_valid,
	output logic signed [hrm_pkg::CORDIC_W-1:0]   x,
	output logic signed [hrm_pkg::CORDIC_W-1:0]   y,
	output logic [1:0]                            quad
);

	localparam int NS = hrm_pkg::CORDIC_STAGES;
	localparam int W  = hrm_pkg::CORDIC_W;

	logic [hrm_pkg::PHASE_W-1:0] phase;
	logic signed [W-1:0]         z_in;

	logic                valid_s [NS];
	logic signed [W-1:0] x_s     [NS];
	logic signed [W-1:0] y_s     [NS];
	logic signed [W-1:0] z_s     [NS];
	logic [1:0]          quad_s  [NS];

	assign phase = hrm_pkg::PHASE_W'(angle) << (hrm_pkg::PHASE_W - ANGLE_BITS);
	assign z_in  = W'(phase[hrm_pkg::RESID_W-1:0]);

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic                vp;
		logic signed [W-1:0] xp, yp, zp, xn, yn, zn;
		logic [1:0]          qp;

		if (i == 0) begin : g_first
			assign vp = in_valid;
			assign xp = hrm_pkg::CORDIC_GAIN;
			assign yp = '0;
			assign zp = z_in;
			assign qp = phase[hrm_pkg::PHASE_W-1 -: 2];
		end else begin : g_next
			assign vp = valid_s[i-1];
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign qp = quad_s[i-1];
		end

		always_comb begin
			if (!zp[W-1]) begin
				xn = xp - (yp >>> i);
				yn = yp + (xp >>> i);
				zn = zp - hrm_pkg::atan_turn(i);
			end else begin
				xn = xp + (yp >>> i);
				yn = yp - (xp >>> i);
				zn = zp + hrm_pkg::atan_turn(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[i] <= 1'b0;
			else
				valid_s[i] <= vp;
		end

		always_ff @(posedge clk) begin
			x_s[i]    <= xn;
			y_s[i]    <= yn;
			z_s[i]    <= zn;
			quad_s[i] <= qp;
		end
	end

	assign out_valid = valid_s[NS-1];
	assign x         = x_s[NS-1];
	assign y         = y_s[NS-1];
	assign quad      = quad_s[NS-1];

endmodule

// File: rtl/core/hrm_combine.sv
// hrm_combine: quadrant fold, constant multiplies, sums, rounding and saturation
// depends on hrm_pkg; fed by hrm_cordic
module hrm_combine #(
	parameter int COEF_FRAC_BITS = hrm_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [hrm_pkg::CORDIC_W-1:0] x,
	input  logic signed [hrm_pkg::CORDIC_W-1:0] y,
	input  logic [1:0]                          quad,
	output logic                                out_valid,
	output logic signed [hrm_pkg::COEF_W-1:0]   diag,
	output logic signed [hrm_pkg::COEF_W-1:0]   plus,
	output logic signed [hrm_pkg::COEF_W-1:0]   minus
);

	localparam int W   = hrm_pkg::CORDIC_W;
	localparam int PW  = hrm_pkg::PROD_W;
	localparam int MW  = W + 31;
	localparam int SH  = 2 * hrm_pkg::Q30_SHIFT - COEF_FRAC_BITS;

	// one third scaled to q.60 plus the rounding half, folded into one constant
	localparam logic signed [PW-1:0] T_BASE =
		(PW'(hrm_pkg::Q30_THIRD) <<< hrm_pkg::Q30_SHIFT) + (PW'(1) <<< (SH - 1));

	logic                 valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [W-1:0]  c_s1, s_s1, c_s2, c_s3;
	logic signed [PW-1:0] mc_s2, ms_s2, ms_s3, t_s3;
	logic signed [PW-1:0] diag_s4, plus_s4, minus_s4;
	logic signed [hrm_pkg::COEF_W-1:0] diag_s5, plus_s5, minus_s5;

	logic signed [W-1:0]  c_fold, s_fold;
	logic signed [MW-1:0] mc, ms;

	always_comb begin
		case (quad)
			hrm_pkg::QUAD_I: begin
				c_fold = x;
				s_fold = y;
			end
			hrm_pkg::QUAD_II: begin
				c_fold = -y;
				s_fold = x;
			end
			hrm_pkg::QUAD_III: begin
				c_fold = -x;
				s_fold = -y;
			end
			default: begin
				c_fold = y;
				s_fold = -x;
			end
		endcase
	end

	assign mc = MW'(c_s1) * MW'(hrm_pkg::Q30_THIRD);
	assign ms = MW'(s_s1) * MW'(hrm_pkg::Q30_INV_SQRT3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		c_s1     <= c_fold;
		s_s1     <= s_fold;
		c_s2     <= c_s1;
		mc_s2    <= PW'(mc);
		ms_s2    <= PW'(ms);
		c_s3     <= c_s2;
		ms_s3    <= ms_s2;
		t_s3     <= T_BASE - mc_s2;
		diag_s4  <= (PW'(c_s3) <<< hrm_pkg::Q30_SHIFT) + t_s3;
		plus_s4  <= t_s3 + ms_s3;
		minus_s4 <= t_s3 - ms_s3;
		diag_s5  <= hrm_pkg::sat_coef(diag_s4 >>> SH);
		plus_s5  <= hrm_pkg::sat_coef(plus_s4 >>> SH);
		minus_s5 <= hrm_pkg::sat_coef(minus_s4 >>> SH);
	end

	assign out_valid = valid_s5;
	assign diag      = diag_s5;
	assign plus      = plus_s5;
	assign minus     = minus_s5;

endmodule

// File: rtl/core/hue_rotation_matrix_unit.sv
// hue_rotation_matrix_unit: top level, hue angle in, 3x3 rgb hue rotation matrix out
// depends on hrm_pkg, hrm_cordic and hrm_combine
//
// Takes one hue angle per beat (start high while busy is low; busy never rises, so an angle
// may be given in every cycle) and returns the nine Q2.14 coefficients, each result shown
// for one cycle with done high. The pipeline is the 20 cordic iterations, one per register
// stage, plus 5 stages for quadrant fold, constant multiplies, sums, rounding and saturation. The
// receiver cannot stall: a result must be taken in the cycle that done is high.
module hue_rotation_matrix_unit #(
	parameter int ANGLE_BITS     = hrm_pkg::ANGLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = hrm_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ANGLE_BITS-1:0]             hue_angle,
	output logic                              done,
	output logic signed [hrm_pkg::COEF_W-1:0] coef_00,
	output logic signed [hrm_pkg::COEF_W-1:0] coef_01,
	output logic signed [hrm_pkg::COEF_W-1:0] coef_02,
	output logic signed [hrm_pkg::COEF_W-1:0] coef_10,
	output logic signed [hrm_pkg::COEF_W-1:0] coef_11,
	output logic signed [hrm_pkg::COEF_W-1:0] coef_12,
	output logic signed [hrm_pkg::COEF_W-1:0] coef_20,
	output logic signed [hrm_pkg::COEF_W-1:0] coef_21,
	output logic signed [hrm_pkg::COEF_W-1:0] coef_22
);

	logic                                cor_valid;
	logic signed [hrm_pkg::CORDIC_W-1:0] cor_x, cor_y;
	logic [1:0]                          cor_quad;
	logic signed [hrm_pkg::COEF_W-1:0]   diag, plus, minus;

	assign busy = 1'b0;

	hrm_cordic #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.angle     (hue_angle),
		.out_valid (cor_valid),
		.x         (cor_x),
		.y         (cor_y),
		.quad      (cor_quad)
	);

	hrm_combine #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cor_valid),
		.x         (cor_x),
		.y         (cor_y),
		.quad      (cor_quad),
		.out_valid (done),
		.diag      (diag),
		.plus      (plus),
		.minus     (minus)
	);

	assign coef_00 = diag;
	assign coef_11 = diag;
	assign coef_22 = diag;
	assign coef_01 = plus;
	assign coef_12 = plus;
	assign coef_20 = plus;
	assign coef_02 = minus;
	assign coef_10 = minus;
	assign coef_21 = minus;

	// every accepted beat is followed by done once it has passed through the whole pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(hrm_pkg::LATENCY) done)
		else $error("result missing after pipeline latency");

	// no result without an accepted beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, hrm_pkg::LATENCY))
		else $error("result without matching input");

	// circulant structure of the rotation matrix
	a_circulant: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (coef_00 == coef_11 && coef_11 == coef_22 && coef_01 == coef_12 &&
			coef_12 == coef_20 && coef_02 == coef_10 && coef_10 == coef_21))
		else $error("matrix not circulant");

endmodule
